FILE: rtl/adrift_pkg.sv
package adrift_pkg;

   localparam int ALT_W = 24;
   localparam int DEV_W = 24;
   localparam int THR_W = 24;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 24'd320;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W = CSR_ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_DRIFT_LIMIT = 1'b0;

   typedef enum logic [1:0] {
      PH_WAIT    = 2'd0,
      PH_GATHER  = 2'd1,
      PH_MONITOR = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ITEM_QUIET = 2'd0,
      ITEM_REF   = 2'd1,
      ITEM_MON   = 2'd2
   } kind_type;

endpackage

FILE: rtl/adrift_if.sv
interface adrift_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [adrift_pkg::ALT_W-1:0]  altitude;

   modport source (output valid, output altitude, input ready);
   modport sink (input valid, input altitude, output ready);
endinterface

interface adrift_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           reference_ready;
   logic                           batch_done;
   logic                           drift_exceeded;
   logic [adrift_pkg::DEV_W-1:0]   max_deviation;

   modport source (output valid, output reference_ready, output batch_done,
                   output drift_exceeded, output max_deviation, input ready);
   modport sink (input valid, input reference_ready, input batch_done,
                 input drift_exceeded, input max_deviation, output ready);
endinterface

FILE: rtl/altitude_drift_detector_unit.sv
// altitude drift detector
// req_chan carries one signed altitude word (1/16 cm) per handshake, rsp_chan returns
// exactly one result word per altitude word, in order.
// the first word after reset is dropped, the next BATCH words set the reference
// (their rounded mean), then every later word is checked against the reference
// and each run of BATCH words ends with a drift flag against the drift limit.
// pipeline: input register, control stage, result register; a word moves from the input
// register through the middle stage into the result register and out on rsp_chan.
// throughput is one word per cycle unless rsp_chan stalls; the reference divide
// is one constant multiply in the middle stage, done in time for the word right
// behind it. when rsp_chan stalls the stages fill up and req_chan.ready falls once all
// three hold a word; an empty stage still takes a word while a result waits.
// reset (synchronous) empties the pipeline, returns to waiting for the first
// word and sets the drift limit to 320 (20 cm).
// the drift limit sits at byte address 0 of the apb port, pready is always high.
module altitude_drift_detector_unit #(
   parameter int BATCH = 15
) (
   input  logic                                   clock,
   input  logic                                   reset,
   adrift_req_if.sink                             req_chan,
   adrift_rsp_if.source                           rsp_chan,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [adrift_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [adrift_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [adrift_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                   pready
);

   localparam int ALT_W = adrift_pkg::ALT_W;
   localparam int DEV_W = adrift_pkg::DEV_W;
   localparam int THR_W = adrift_pkg::THR_W;
   localparam int CSR_DATA_W = adrift_pkg::CSR_DATA_W;
   localparam int CNT_W = (BATCH > 1) ? $clog2(BATCH) : 1;
   localparam int SUM_W = ALT_W + $clog2(BATCH);
   localparam int NUM_W = SUM_W + 2;
   localparam int DIV = 2 * BATCH;
   localparam int K = NUM_W + $clog2(DIV);
   localparam int RCP_W = NUM_W + 1;
   localparam int PROD_W = NUM_W + RCP_W;
   localparam logic [63:0] RCP_FULL = ((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV);
   localparam logic [RCP_W-1:0] RCP = RCP_FULL[RCP_W-1:0];
   localparam logic [CNT_W-1:0] LAST = CNT_W'(BATCH - 1);

   // handshake flow
   logic s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic out_take, s2_move, s2_free, s1_move, s1_free, req_acc;

   assign out_take = !out_valid_ff || rsp_chan.ready;
   assign s2_move  = s2_valid_ff && out_take;
   assign s2_free  = !s2_valid_ff || out_take;
   assign s1_move  = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign req_acc  = req_chan.valid && s1_free;
   assign req_chan.ready = s1_free;

   // configuration
   logic [THR_W-1:0] threshold_ff;
   logic [adrift_pkg::REG_IDX_W-1:0] reg_idx;
   logic csr_write;

   assign reg_idx   = paddr[adrift_pkg::CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (reg_idx == adrift_pkg::REG_DRIFT_LIMIT) ?
                      CSR_DATA_W'(threshold_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= adrift_pkg::THRESHOLD_RESET;
      end else if (csr_write && reg_idx == adrift_pkg::REG_DRIFT_LIMIT) begin
         threshold_ff <= pwdata[THR_W-1:0];
      end
   end

   // input register
   logic signed [ALT_W-1:0] s1_alt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_acc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_alt_ff <= req_chan.altitude;
      end
   end

   // control stage: phase, count and reference sum
   adrift_pkg::phase_type phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in, sum_add;
   logic signed [NUM_W-1:0] sum_ext, num_pos, num_neg;
   logic last_word;
   adrift_pkg::kind_type kind_in;

   assign sum_add   = sum_ff + SUM_W'(s1_alt_ff);
   assign sum_ext   = NUM_W'(sum_add);
   assign num_pos   = (sum_ext <<< 1) + NUM_W'(BATCH);
   assign num_neg   = NUM_W'(BATCH) - (sum_ext <<< 1);
   assign last_word = (count_ff == LAST);

   always_comb begin
      case (phase_ff)
         adrift_pkg::PH_WAIT:   phase_in = adrift_pkg::PH_GATHER;
         adrift_pkg::PH_GATHER: phase_in = last_word ? adrift_pkg::PH_MONITOR :
                                                       adrift_pkg::PH_GATHER;
         default:               phase_in = adrift_pkg::PH_MONITOR;
      endcase
   end

   always_comb begin
      kind_in  = adrift_pkg::ITEM_QUIET;
      count_in = count_ff;
      sum_in   = sum_ff;
      case (phase_ff)
         adrift_pkg::PH_WAIT: begin
            count_in = '0;
            sum_in   = '0;
         end
         adrift_pkg::PH_GATHER: begin
            if (last_word) begin
               kind_in  = adrift_pkg::ITEM_REF;
               count_in = '0;
               sum_in   = '0;
            end else begin
               count_in = count_ff + 1'b1;
               sum_in   = sum_add;
            end
         end
         default: begin
            kind_in  = adrift_pkg::ITEM_MON;
            count_in = last_word ? '0 : count_ff + 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= adrift_pkg::PH_WAIT;
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (s1_move) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   // middle stage registers
   adrift_pkg::kind_type s2_kind_ff;
   logic s2_last_ff, s2_neg_ff;
   logic signed [ALT_W-1:0] s2_alt_ff;
   logic [NUM_W-1:0] s2_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_move) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_move) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_kind_ff <= kind_in;
         s2_last_ff <= last_word;
         s2_alt_ff  <= s1_alt_ff;
         s2_neg_ff  <= sum_add[SUM_W-1];
         s2_num_ff  <= sum_add[SUM_W-1] ? num_neg : num_pos;
      end
   end

   // mean = floor((2|sum| + n) / 2n) by reciprocal multiply, sign put back after
   logic [PROD_W-1:0] product;
   logic [ALT_W-1:0] quot, quot_neg;
   logic signed [ALT_W-1:0] reference_ff, reference_in;

   assign product  = s2_num_ff * RCP;
   assign quot     = product[K +: ALT_W];
   assign quot_neg = ALT_W'(~quot + ALT_W'(1));
   assign reference_in = s2_neg_ff ? quot_neg : quot;

   // deviation against the reference
   logic signed [ALT_W:0] dev;
   logic [ALT_W:0] dev_mag;
   logic [DEV_W-1:0] dev_sat, peak_ff, peak_new, peak_in;
   logic exceeded;

   assign dev      = (ALT_W + 1)'(s2_alt_ff) - (ALT_W + 1)'(reference_ff);
   assign dev_mag  = dev[ALT_W] ? (ALT_W + 1)'(-dev) : dev;
   assign dev_sat  = dev_mag[ALT_W] ? '1 : dev_mag[DEV_W-1:0];
   assign peak_new = (dev_sat > peak_ff) ? dev_sat : peak_ff;
   assign exceeded = (peak_new > threshold_ff);

   logic o_ready_in, o_done_in, o_exceeded_in;
   logic [DEV_W-1:0] o_maxdev_in;
   logic ref_load;

   always_comb begin
      o_ready_in    = 1'b0;
      o_done_in     = 1'b0;
      o_exceeded_in = 1'b0;
      o_maxdev_in   = '0;
      ref_load      = 1'b0;
      peak_in       = peak_ff;
      case (s2_kind_ff)
         adrift_pkg::ITEM_REF: begin
            o_ready_in = 1'b1;
            ref_load   = 1'b1;
            peak_in    = '0;
         end
         adrift_pkg::ITEM_MON: begin
            o_ready_in    = 1'b1;
            o_maxdev_in   = peak_new;
            o_done_in     = s2_last_ff;
            o_exceeded_in = s2_last_ff && exceeded;
            peak_in       = s2_last_ff ? '0 : peak_new;
         end
         default: begin
            peak_in = peak_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_ff <= '0;
         peak_ff      <= '0;
      end else if (s2_move) begin
         if (ref_load) begin
            reference_ff <= reference_in;
         end
         peak_ff <= peak_in;
      end
   end

   // result register
   logic o_ready_ff, o_done_ff, o_exceeded_ff;
   logic [DEV_W-1:0] o_maxdev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s2_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         o_ready_ff    <= o_ready_in;
         o_done_ff     <= o_done_in;
         o_exceeded_ff <= o_exceeded_in;
         o_maxdev_ff   <= o_maxdev_in;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.reference_ready = o_ready_ff;
   assign rsp_chan.batch_done      = o_done_ff;
   assign rsp_chan.drift_exceeded  = o_exceeded_ff;
   assign rsp_chan.max_deviation   = o_maxdev_ff;

endmodule
